// ===== sv/ipv4hv_pkg.sv =====
// Shared types and constants for the IPv4 header validator.
// No dependencies; imported by ipv4hv_accum and ipv4_header_validator_core.
`default_nettype none

package ipv4hv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned OFFSET_W = 6;

    localparam logic [COUNT_W-1:0] HDR_MIN_LEN = COUNT_W'(20);
    localparam logic [COUNT_W-1:0] COUNT_CAP   = COUNT_W'(60);
    localparam logic [COUNT_W-1:0] STORED_HI   = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] STORED_LO   = COUNT_W'(11);
    localparam logic [3:0]         IP_VERSION  = 4'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_CSUM_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] data_offset;
        status_t             status;
    } result_t;

    // 16-bit ones'-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/ipv4_header_validator_core.sv =====
// IPv4 header validator top level: input beat register, header accumulator,
// status output register. Depends on ipv4hv_pkg and ipv4hv_accum.
//
// Takes one packet byte per beat and returns one status beat per packet.
// The status beat is registered: the tlast byte passes the input register,
// then its status is loaded into the status register and offered on m_tvalid.
// A byte is accepted every cycle, unless a last byte is held in the input
// register. Only a last byte waits on the output side: it leaves the input
// register once the status register is empty or being drained. The
// status is 0 for a good header, 1 for a malformed header or length
// (including options), 2 for a checksum mismatch; the data offset is IHL*4
// once length, version and IHL checks pass, else 0.
`default_nettype none

module ipv4_header_validator_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [1:0] status, [7:2] data_offset
);
    import ipv4hv_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic    out_free;
    logic    consume;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    ipv4hv_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && consume && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.data_offset, out_reg.status};

endmodule

`default_nettype wire

// ===== sv/ipv4hv_accum.sv =====
// Per-packet header state: byte count, version/IHL, stored checksum, running sum.
// Produces the status for the packet's last byte. Depends on ipv4hv_pkg.
`default_nettype none

module ipv4hv_accum (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire logic [ipv4hv_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        last_byte,
    output ipv4hv_pkg::result_t              result
);
    import ipv4hv_pkg::*;

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [BYTE_W-1:0]  ver_ihl_reg, ver_ihl_next;
    logic [BYTE_W-1:0]  hold_reg,    hold_next;
    logic [WORD_W-1:0]  sum_reg,     sum_next;
    logic [WORD_W-1:0]  stored_reg,  stored_next;

    logic               in_hdr;
    logic               csum_byte;
    logic [BYTE_W-1:0]  sum_byte;
    logic [OFFSET_W-1:0] ihl_bytes;
    logic               hdr_ok;

    always_comb begin
        in_hdr    = count_reg < HDR_MIN_LEN;
        csum_byte = (count_reg == STORED_HI) || (count_reg == STORED_LO);
        sum_byte  = csum_byte ? '0 : data_byte;

        ver_ihl_next = ver_ihl_reg;
        stored_next  = stored_reg;
        hold_next    = hold_reg;
        sum_next     = sum_reg;
        if (in_hdr) begin
            if (count_reg == '0) begin
                ver_ihl_next = data_byte;
            end
            if (count_reg == STORED_HI) begin
                stored_next = {data_byte, 8'h00};
            end
            if (count_reg == STORED_LO) begin
                stored_next = {stored_reg[WORD_W-1:BYTE_W], data_byte};
            end
            if (!count_reg[0]) begin
                hold_next = sum_byte;
            end else begin
                sum_next = oc_add(sum_reg, {hold_reg, sum_byte});
            end
        end
        count_next = (count_reg < COUNT_CAP) ? count_reg + 1'b1 : count_reg;

        ihl_bytes = {ver_ihl_next[3:0], 2'b00};
        hdr_ok    = (count_next >= HDR_MIN_LEN)
                 && (ver_ihl_next[7:4] == IP_VERSION)
                 && (ihl_bytes >= HDR_MIN_LEN)
                 && (count_next >= ihl_bytes);

        result.status      = STATUS_MALFORMED;
        result.data_offset = '0;
        if (hdr_ok) begin
            result.data_offset = ihl_bytes;
            if (ihl_bytes > HDR_MIN_LEN) begin
                result.status = STATUS_MALFORMED;
            end else if (~sum_next != stored_next) begin
                result.status = STATUS_CSUM_BAD;
            end else begin
                result.status = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ver_ihl_reg <= '0;
            hold_reg    <= '0;
            sum_reg     <= '0;
            stored_reg  <= '0;
        end else if (step) begin
            if (last_byte) begin
                // drop all per-packet state after the status is taken
                count_reg   <= '0;
                ver_ihl_reg <= '0;
                hold_reg    <= '0;
                sum_reg     <= '0;
                stored_reg  <= '0;
            end else begin
                count_reg   <= count_next;
                ver_ihl_reg <= ver_ihl_next;
                hold_reg    <= hold_next;
                sum_reg     <= sum_next;
                stored_reg  <= stored_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_ipv4_header_validator_core.sv =====
// Self-checking testbench for ipv4_header_validator_core: packet bytes in, one status beat out.
// Predicts status and data offset per packet and compares them against the result stream.
// Depends on ipv4hv_pkg and the core RTL.
module tb_ipv4_header_validator_core;
    import ipv4hv_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pkt_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] status, [7:2] data_offset

    pkt_byte_t   tx_bytes[$];
    result_t     want_results[$];
    int          fail_count = 0;
    int unsigned cyc = 0;
    logic        calm_window;
    logic        sink_hold;

    // per-packet header tracking
    logic [5:0]  pk_count   = '0;
    logic [7:0]  pk_ver_ihl = '0;
    logic [7:0]  pk_hi_byte = '0;
    logic [15:0] pk_sum     = '0;
    logic [15:0] pk_stored  = '0;

    ipv4_header_validator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cyc <= 0;
        end else begin
            cyc <= cyc + 1;
        end
    end

    assign calm_window = (cyc >= 300) && (cyc < 900);
    assign sink_hold   = (cyc >= 1500) && (cyc < 1800);

    function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[16]) begin
            s = {1'b0, s[15:0]} + 17'd1;
        end
        return s[15:0];
    endfunction

    function automatic void ipv4_track_byte(input logic [7:0] d, input logic lst);
        logic [7:0] v;
        logic [5:0] hdr_bytes;
        result_t    r;
        v = d;
        if (pk_count < HDR_MIN_LEN) begin
            if (pk_count == '0) pk_ver_ihl = d;
            if (pk_count == STORED_HI) pk_stored = {d, 8'h00};
            if (pk_count == STORED_LO) pk_stored[7:0] = d;
            // checksum field counts as zero in the sum
            if (pk_count == STORED_HI || pk_count == STORED_LO) v = 8'h00;
            if (!pk_count[0]) begin
                pk_hi_byte = v;
            end else begin
                pk_sum = wrap_add(pk_sum, {pk_hi_byte, v});
            end
        end
        if (pk_count < COUNT_CAP) pk_count++;
        if (lst) begin
            hdr_bytes = {pk_ver_ihl[3:0], 2'b00};
            r.status = STATUS_MALFORMED;
            r.data_offset = '0;
            if (pk_count >= HDR_MIN_LEN && pk_ver_ihl[7:4] == IP_VERSION &&
                hdr_bytes >= HDR_MIN_LEN && pk_count >= hdr_bytes) begin
                r.data_offset = hdr_bytes;
                if (hdr_bytes > HDR_MIN_LEN) begin
                    r.status = STATUS_MALFORMED;
                end else if (~pk_sum != pk_stored) begin
                    r.status = STATUS_CSUM_BAD;
                end else begin
                    r.status = STATUS_OK;
                end
            end
            want_results.push_back(r);
            pk_count   = '0;
            pk_ver_ihl = '0;
            pk_hi_byte = '0;
            pk_sum     = '0;
            pk_stored  = '0;
        end
    endfunction

    // Build a header with a valid checksum, then optionally flip bits in one header byte.
    // Packets shorter than 20 bytes are truncated headers; longer ones get random payload.
    task automatic add_packet(input logic [3:0] ver, input logic [3:0] ihl, input int len,
                              input int corrupt_at);
        logic [7:0]  hdr [20];
        logic [15:0] sum;
        pkt_byte_t   pb;
        int          k;
        for (k = 0; k < 20; k++) hdr[k] = 8'($urandom);
        hdr[0]  = {ver, ihl};
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        sum = 16'h0000;
        for (k = 0; k < 20; k += 2) sum = wrap_add(sum, {hdr[k], hdr[k+1]});
        {hdr[10], hdr[11]} = ~sum;
        if (corrupt_at >= 0) hdr[corrupt_at] ^= 8'($urandom_range(255, 1));
        for (k = 0; k < len; k++) begin
            pb.data = (k < 20) ? hdr[k] : 8'($urandom);
            pb.last = (k == len - 1);
            tx_bytes.push_back(pb);
        end
    endtask

    task automatic add_noise(input int len, input bit use_fill, input logic [7:0] fill);
        pkt_byte_t pb;
        int        k;
        for (k = 0; k < len; k++) begin
            pb.data = use_fill ? fill : 8'($urandom);
            pb.last = (k == len - 1);
            tx_bytes.push_back(pb);
        end
    endtask

    // driver: hold a beat until accepted, then advance or idle
    always @(posedge aclk) begin
        logic gap;
        gap = ($urandom_range(99, 0) < 36) && !calm_window;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                ipv4_track_byte(s_tdata, s_tlast);
                void'(tx_bytes.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (tx_bytes.size() != 0 && !gap) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_bytes[0].data;
                    s_tlast  <= tx_bytes[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each status beat with the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (want_results.size() == 0) begin
                    $display("%0t unexpected beat: expected none, actual 0x%02h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = want_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.data_offset != want.data_offset) begin
                        $display("%0t data_offset: expected %0d, actual %0d",
                                 $time, want.data_offset, got.data_offset);
                        fail_count++;
                    end
                end
            end
            if (sink_hold) begin
                m_tready <= 1'b0;
            end else if (calm_window) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= 36);
            end
        end
    end

    initial begin
        int       target;
        int       sel;
        int       len;
        int       guard;
        logic [3:0] ver;
        logic [3:0] ihl;

        // directed packets
        add_packet(4'd4, 4'd5, 20, -1);        // good header, exactly 20 bytes
        add_packet(4'd4, 4'd5, 20, 5);         // checksum mismatch
        add_noise(20, 1'b1, 8'h00);            // all zeros
        add_noise(20, 1'b1, 8'hff);            // all ones
        add_packet(4'd4, 4'd5, 1, -1);         // single-byte packet
        add_packet(4'd4, 4'd5, 19, -1);        // one byte short
        add_packet(4'd4, 4'd6, 24, -1);        // options present
        add_packet(4'd4, 4'd6, 22, -1);        // IHL longer than packet
        add_packet(4'd4, 4'd0, 20, -1);        // IHL zero
        add_packet(4'd4, 4'd4, 20, -1);        // IHL just below minimum
        add_packet(4'd6, 4'd5, 20, -1);        // wrong version
        add_packet(4'd4, 4'd15, 60, -1);       // largest IHL, fits exactly
        add_packet(4'd4, 4'd5, 70, -1);        // long payload, count saturates

        target = 1950;
        while (tx_bytes.size() < target) begin
            sel = $urandom_range(99, 0);
            if (sel < 60) begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 41) : $urandom_range(40, 20);
                add_packet(4'd4, 4'd5, len, (sel < 45) ? -1 : int'($urandom_range(19, 0)));
            end else if (sel < 70) begin
                ihl = 4'($urandom_range(15, 6));
                add_packet(4'd4, ihl, $urandom_range(64, 20), -1);
            end else if (sel < 78) begin
                add_packet(4'd4, 4'($urandom_range(4, 0)), $urandom_range(30, 20), -1);
            end else if (sel < 85) begin
                ver = 4'($urandom_range(15, 0));
                if (ver == IP_VERSION) ver = 4'd5;
                add_packet(ver, 4'($urandom), $urandom_range(30, 20), -1);
            end else if (sel < 93) begin
                add_packet(4'($urandom), 4'($urandom), $urandom_range(19, 1), -1);
            end else begin
                add_noise($urandom_range(70, 1), 1'b0, 8'h00);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (tx_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        guard = 0;
        while (want_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (want_results.size() != 0) begin
            $display("%0t %0d status beats expected, actual none", $time, want_results.size());
            fail_count++;
        end
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ipv4hv_pkg.sv
sv/ipv4hv_accum.sv
sv/ipv4_header_validator_core.sv
verif/tb_ipv4_header_validator_core.sv
